// ----- rtl/motif_automorphism_orbits_unit_defines.svh -----
// Assertion macros shared by the orbit unit. Simulation builds get the
// concurrent assertions; synthesis builds get empty bodies.
`ifndef MOTIF_AUTOMORPHISM_ORBITS_UNIT_DEFINES_SVH
`define MOTIF_AUTOMORPHISM_ORBITS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define MAO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define MAO_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define MAO_ASSERT(label, clk, rst_n, prop, msg)
`define MAO_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/mao_pkg.sv -----
package mao_pkg;

    // Largest motif the unit handles.
    localparam int MaxNodes = 8;
    // Bits of a node id.
    localparam int IdxW = $clog2(MaxNodes);
    // Bits of a count that can reach MaxNodes itself.
    localparam int CntW = $clog2(MaxNodes + 1);
    // Width of the node_count register field.
    localparam int NodeCountW = 4;
    // Configuration port widths.
    localparam int AddrW = 3;
    localparam int DataW = 32;

    // Adjacency matrix: adj[row][col] is set for an edge row -> col.
    typedef logic [MaxNodes-1:0][MaxNodes-1:0] adj_mat_t;

    typedef enum logic {
        ReqEdge    = 1'b0,
        ReqCompute = 1'b1
    } req_t;

    // Register index, taken from paddr bit 2.
    typedef enum logic {
        RegNodeCount  = 1'b0,
        RegIsDirected = 1'b1
    } cfg_reg_t;

    // Start command from the front end to the search sequencer.
    typedef struct packed {
        logic            start;
        logic [CntW-1:0] n;
    } ctl_t;

    // Status from the search sequencer back to the front end.
    typedef struct packed {
        logic            busy;
        logic            row_valid;
        logic [IdxW-1:0] row_index;
        logic            last;
        logic            clear_adj;
    } status_t;

endpackage

// ----- rtl/motif_automorphism_orbits_unit.sv -----
// Automorphism orbit unit for motifs of up to eight nodes. Edge requests
// (req_type 0) set one bit of the adjacency matrix, or both directions when
// is_directed is 0, one per cycle while idle. A compute request (req_type 1)
// starts a depth-first permutation search over nodes 0..node_count-1 (a
// node_count above eight acts as eight) and then returns one result per node:
// the node id, a mask of every node it can be mapped to by some automorphism,
// and a flag on the final row. After the last row is handed over the matrix
// is cleared for the next motif; node_count 0 returns no rows and only clears
// the matrix. The search runs on one shared pair-compare unit under a small
// sequencer. After the accepting edge every cycle does exactly one step:
// compare the candidate against one earlier placement, skip a candidate that
// is already taken, place a candidate that passed every compare, give up on a
// level whose candidates ran out and pop it, or record one automorphism and
// pop the last level. A failed compare moves to the next candidate in the
// same cycle. The rows then leave one per cycle while out_stall does not hold
// them back. in_stall stays high for the whole computation and row output.
// Results wait in a single output register, so a stalled consumer only
// holds up the row sequence, never the matrix.
module motif_automorphism_orbits_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mao_pkg::AddrW-1:0]         paddr,
    input  logic [mao_pkg::DataW-1:0]         pwdata,
    output logic [mao_pkg::DataW-1:0]         prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [mao_pkg::IdxW-1:0]          edge_from,
    input  logic [mao_pkg::IdxW-1:0]          edge_to,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mao_pkg::IdxW-1:0]          node_index,
    output logic [mao_pkg::MaxNodes-1:0]      orbit_mask,
    output logic                              last_row
);
    import mao_pkg::*;

`include "motif_automorphism_orbits_unit_defines.svh"

    logic [NodeCountW-1:0] node_count_reg;
    logic                  is_directed_reg;
    adj_mat_t              adj_reg, adj_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IdxW-1:0]       node_index_reg;
    logic [MaxNodes-1:0]   orbit_mask_reg;
    logic                  last_row_reg;

    logic                  cfg_write;
    cfg_reg_t              cfg_sel;
    logic                  in_accept;
    logic                  out_take;
    logic                  row_load;
    logic [CntW-1:0]       n_clamped;
    ctl_t                  ctl;
    status_t               status;
    logic [MaxNodes-1:0]   orbit_row;

    // Configuration port: zero wait states, register picked by address bit 2.
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_sel)
            RegNodeCount:  prdata = DataW'(node_count_reg);
            RegIsDirected: prdata = DataW'(is_directed_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= NodeCountW'(3);
            is_directed_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                RegNodeCount:  node_count_reg  <= pwdata[NodeCountW-1:0];
                RegIsDirected: is_directed_reg <= pwdata[0];
                default:       node_count_reg  <= node_count_reg;
            endcase
        end
    end

    // Requests are taken only while the sequencer is idle.
    assign in_stall  = status.busy;
    assign in_accept = in_valid && !in_stall;

    assign n_clamped = (node_count_reg > NodeCountW'(MaxNodes))
                     ? CntW'(MaxNodes) : CntW'(node_count_reg);

    assign ctl.start = in_accept && (req_t'(req_type) == ReqCompute);
    assign ctl.n     = n_clamped;

    // Adjacency matrix: set by edge requests, wiped after each result run.
    always_comb
    begin
        adj_next = adj_reg;
        if (status.clear_adj)
        begin
            adj_next = '0;
        end
        else if (in_accept && (req_t'(req_type) == ReqEdge))
        begin
            adj_next[edge_from][edge_to] = 1'b1;
            if (!is_directed_reg)
            begin
                adj_next[edge_to][edge_from] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg <= '0;
        end
        else
        begin
            adj_reg <= adj_next;
        end
    end

    mao_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .adj       (adj_reg),
        .take      (out_take),
        .status    (status),
        .orbit_row (orbit_row)
    );

    // Output register: a new row loads when the slot is empty or being taken.
    assign out_take = !out_valid_reg || !out_stall;
    assign row_load = status.row_valid && out_take;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (row_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_load)
        begin
            node_index_reg <= status.row_index;
            orbit_mask_reg <= orbit_row;
            last_row_reg   <= status.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign node_index = node_index_reg;
    assign orbit_mask = orbit_mask_reg;
    assign last_row   = last_row_reg;

    // The identity is always an automorphism, so each row maps to itself.
    `MAO_ASSERT(a_row_has_self, clk, rst_n,
        status.row_valid |-> orbit_row[status.row_index],
        "orbit row lacks its own node")
    // Handing over the final row returns the sequencer to idle.
    `MAO_ASSERT(a_last_row_idles, clk, rst_n,
        (row_load && status.last) |=> !status.busy,
        "sequencer still busy after final row")
    // Rows leave in ascending node order without gaps.
    `MAO_ASSERT(a_rows_in_order, clk, rst_n,
        (row_load && !status.last) |=> (status.row_valid
            && (status.row_index == $past(status.row_index) + IdxW'(1))),
        "orbit rows out of order")
    // A clear always leaves an empty matrix behind.
    `MAO_ASSERT(a_adj_cleared, clk, rst_n,
        status.clear_adj |=> (adj_reg == '0),
        "adjacency matrix not cleared")

endmodule

// ----- rtl/mao_pair_check.sv -----
// Compares one earlier placement against the candidate in both directions.
module mao_pair_check (
    input  mao_pkg::adj_mat_t          adj,
    input  logic [mao_pkg::IdxW-1:0]   cand,
    input  logic [mao_pkg::IdxW-1:0]   depth,
    input  logic [mao_pkg::IdxW-1:0]   chk,
    input  logic [mao_pkg::IdxW-1:0]   pj,
    output logic                       match
);
    import mao_pkg::*;

    logic fwd_ok;
    logic rev_ok;

    // Edge cand -> perm[chk] must mirror edge depth -> chk, and likewise back.
    assign fwd_ok = (adj[cand][pj] == adj[depth][chk]);
    assign rev_ok = (adj[pj][cand] == adj[chk][depth]);
    assign match  = fwd_ok & rev_ok;

endmodule

// ----- rtl/mao_search.sv -----
// Depth-first automorphism search sequencer with orbit store and row emitter.
module mao_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mao_pkg::ctl_t                  ctl,
    input  mao_pkg::adj_mat_t              adj,
    input  logic                           take,
    output mao_pkg::status_t               status,
    output logic [mao_pkg::MaxNodes-1:0]   orbit_row
);
    import mao_pkg::*;

    typedef enum logic [3:0] {
        StIdle   = 4'b0001,
        StScan   = 4'b0010,
        StRecord = 4'b0100,
        StEmit   = 4'b1000
    } st_t;

    st_t                 state_reg, state_next;
    logic [CntW-1:0]     n_reg, n_next;
    logic [CntW-1:0]     depth_reg, depth_next;
    logic [CntW-1:0]     cand_reg, cand_next;
    logic [IdxW-1:0]     chk_reg, chk_next;
    logic [MaxNodes-1:0] used_reg, used_next;
    logic [IdxW-1:0]     row_reg, row_next;
    logic [MaxNodes-1:0] orbit_reg [MaxNodes];
    logic [MaxNodes-1:0] orbit_next [MaxNodes];
    logic [IdxW-1:0]     perm_reg [MaxNodes];
    logic [IdxW-1:0]     perm_next [MaxNodes];
    logic [CntW-1:0]     resume_reg [MaxNodes];
    logic [CntW-1:0]     resume_next [MaxNodes];

    logic [IdxW-1:0]     cand_idx;
    logic [IdxW-1:0]     depth_idx;
    logic [CntW-1:0]     depth_dec;
    logic [CntW-1:0]     resume_top;
    logic [CntW-1:0]     released;
    logic                pair_ok;
    logic                row_last;

    assign cand_idx   = cand_reg[IdxW-1:0];
    assign depth_idx  = depth_reg[IdxW-1:0];
    assign depth_dec  = depth_reg - CntW'(1);
    // The resume slot holds the popped node plus one.
    assign resume_top = resume_reg[depth_dec[IdxW-1:0]];
    assign released   = resume_top - CntW'(1);
    assign row_last   = (CntW'(row_reg) == n_reg - CntW'(1));

    mao_pair_check u_pair_check (
        .adj   (adj),
        .cand  (cand_idx),
        .depth (depth_idx),
        .chk   (chk_reg),
        .pj    (perm_reg[chk_reg]),
        .match (pair_ok)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        depth_next  = depth_reg;
        cand_next   = cand_reg;
        chk_next    = chk_reg;
        used_next   = used_reg;
        row_next    = row_reg;
        orbit_next  = orbit_reg;
        perm_next   = perm_reg;
        resume_next = resume_reg;

        case (state_reg)
            StIdle:
            begin
                if (ctl.start)
                begin
                    n_next     = ctl.n;
                    depth_next = '0;
                    cand_next  = '0;
                    chk_next   = '0;
                    used_next  = '0;
                    row_next   = '0;
                    for (int i = 0; i < MaxNodes; i++)
                    begin
                        orbit_next[i] = '0;
                    end
                    if (ctl.n != '0)
                    begin
                        state_next = StScan;
                    end
                end
            end

            StScan:
            begin
                if (cand_reg >= n_reg)
                begin
                    // Candidates exhausted at this depth.
                    if (depth_reg == '0)
                    begin
                        used_next  = '0;
                        state_next = StEmit;
                    end
                    else
                    begin
                        depth_next = depth_dec;
                        used_next[released[IdxW-1:0]] = 1'b0;
                        cand_next  = resume_top;
                        chk_next   = '0;
                    end
                end
                else if (used_reg[cand_idx])
                begin
                    cand_next = cand_reg + CntW'(1);
                    chk_next  = '0;
                end
                else if (CntW'(chk_reg) == depth_reg)
                begin
                    // Candidate agrees with every earlier placement.
                    perm_next[depth_idx]   = cand_idx;
                    resume_next[depth_idx] = cand_reg + CntW'(1);
                    used_next[cand_idx]    = 1'b1;
                    depth_next             = depth_reg + CntW'(1);
                    cand_next              = '0;
                    chk_next               = '0;
                    if (depth_reg + CntW'(1) == n_reg)
                    begin
                        state_next = StRecord;
                    end
                end
                else if (pair_ok)
                begin
                    chk_next = chk_reg + IdxW'(1);
                end
                else
                begin
                    cand_next = cand_reg + CntW'(1);
                    chk_next  = '0;
                end
            end

            StRecord:
            begin
                for (int i = 0; i < MaxNodes; i++)
                begin
                    if (CntW'(i) < n_reg)
                    begin
                        orbit_next[i][perm_reg[i]] = 1'b1;
                    end
                end
                depth_next = depth_dec;
                used_next[released[IdxW-1:0]] = 1'b0;
                cand_next  = resume_top;
                chk_next   = '0;
                state_next = StScan;
            end

            StEmit:
            begin
                if (take)
                begin
                    if (row_last)
                    begin
                        state_next = StIdle;
                    end
                    else
                    begin
                        row_next = row_reg + IdxW'(1);
                    end
                end
            end

            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            n_reg     <= '0;
            depth_reg <= '0;
            cand_reg  <= '0;
            chk_reg   <= '0;
            used_reg  <= '0;
            row_reg   <= '0;
            for (int i = 0; i < MaxNodes; i++)
            begin
                orbit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            depth_reg <= depth_next;
            cand_reg  <= cand_next;
            chk_reg   <= chk_next;
            used_reg  <= used_next;
            row_reg   <= row_next;
            orbit_reg <= orbit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        perm_reg   <= perm_next;
        resume_reg <= resume_next;
    end

    always_comb
    begin
        status.busy      = (state_reg != StIdle);
        status.row_valid = (state_reg == StEmit);
        status.row_index = row_reg;
        status.last      = row_last;
        status.clear_adj = ((state_reg == StIdle) && ctl.start && (ctl.n == '0))
                         || ((state_reg == StEmit) && take && row_last);
    end

    assign orbit_row = orbit_reg[row_reg];

endmodule
